[hw/rtl/abwds_pkg.sv]
// Shared types, codes and reset constants of the antenna burn-wire deployment sequencer.
package abwds_pkg;

    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;
    localparam int SETTLE_STEPS = 6;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [1:0] REG_BURN_HALF = 2'd0;
    localparam logic [1:0] REG_REST      = 2'd1;
    localparam logic [1:0] REG_RECHECK   = 2'd2;
    localparam logic [1:0] REG_TRY_LIMIT = 2'd3;

    localparam logic [15:0] BURN_HALF_RST = 16'd45311;
    localparam logic [15:0] REST_RST      = 16'd5000;
    localparam logic [15:0] RECHECK_RST   = 16'd2000;
    localparam logic [3:0]  TRY_LIMIT_RST = 4'd10;
    localparam logic [15:0] RECHECK_LIMIT = 16'd10000;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_BURN1   = 3'd1,
        PH_REST1   = 3'd2,
        PH_BURN2   = 3'd3,
        PH_REST2   = 3'd4,
        PH_RECHECK = 3'd5
    } phase_t;

    typedef struct packed {
        logic [15:0] burn_half;
        logic [15:0] rest;
        logic [15:0] recheck;
        logic [3:0]  try_limit;
    } cfg_t;

    typedef struct packed {
        logic       ant_common_en;
        logic       ant_one_en;
        logic       ant_two_en;
        logic       busy;
        logic       finished;
        logic       deployed;
        logic [4:0] tries_recorded;
    } status_t;

endpackage

[hw/rtl/abwds_regs.sv]
// APB configuration registers of the deployment sequencer.
module abwds_regs
    import abwds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_BURN_HALF: cfg_next.burn_half = pwdata[15:0];
                REG_REST:      cfg_next.rest      = pwdata[15:0];
                REG_RECHECK:   cfg_next.recheck   = pwdata[15:0];
                REG_TRY_LIMIT: cfg_next.try_limit = pwdata[3:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_BURN_HALF: prdata = APB_DATA_W'(cfg_reg.burn_half);
            REG_REST:      prdata = APB_DATA_W'(cfg_reg.rest);
            REG_RECHECK:   prdata = APB_DATA_W'(cfg_reg.recheck);
            REG_TRY_LIMIT: prdata = APB_DATA_W'(cfg_reg.try_limit);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.burn_half <= BURN_HALF_RST;
            cfg_reg.rest      <= REST_RST;
            cfg_reg.recheck   <= RECHECK_RST;
            cfg_reg.try_limit <= TRY_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hw/rtl/abwds_seq.sv]
// Phase sequencer: phase timer, try counter and deployment record.
module abwds_seq
    import abwds_pkg::*;
#(
    parameter int TIMER_BITS = 17
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [1:0] kind,
    input  logic       check_level,
    input  cfg_t       cfg,
    output status_t    status
);

    typedef struct packed {
        phase_t     phase;
        logic [4:0] try_count;
        logic       deployed;
        logic [4:0] tries_rec;
        logic       finished;
        logic       moved;
    } walk_t;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [TIMER_BITS-1:0] timer_reg;
    logic [TIMER_BITS-1:0] timer_next;
    logic [4:0]            try_reg;
    logic [4:0]            try_next;
    logic                  deployed_reg;
    logic                  deployed_next;
    logic [4:0]            tries_rec_reg;
    logic [4:0]            tries_rec_next;
    logic                  finished_reg;
    logic                  finished_next;

    logic [TIMER_BITS-1:0] dur_burn;
    logic [TIMER_BITS-1:0] dur_rest;
    logic [TIMER_BITS-1:0] dur_recheck;
    logic [TIMER_BITS-1:0] timer_dec;
    logic                  zero_burn;
    logic                  zero_rest;
    logic                  zero_recheck;
    logic [3:0]            eff_max;
    logic                  settle_en;
    logic                  zero_now;
    walk_t                 w;

    function automatic walk_t end_phase(walk_t cur, logic level, logic fail_all,
                                        logic [3:0] max_eff);
        walk_t r;
        logic  fail;
        r       = cur;
        fail    = 1'b0;
        r.moved = 1'b1;
        case (cur.phase)
            PH_BURN1: r.phase = PH_REST1;
            PH_REST1: r.phase = PH_BURN2;
            PH_BURN2: r.phase = PH_REST2;
            PH_REST2:
            begin
                if (!level)
                    r.phase = PH_RECHECK;
                else
                    fail = 1'b1;
            end
            PH_RECHECK:
            begin
                if (!level)
                begin
                    r.deployed  = 1'b1;
                    r.tries_rec = cur.try_count;
                    r.finished  = 1'b1;
                    r.try_count = '0;
                    r.phase     = PH_IDLE;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            default: r.phase = PH_IDLE;
        endcase
        if (fail)
        begin
            // a try with zero burn and rest phases and a high pin fails every remaining try at once
            if ((cur.try_count >= {1'b0, max_eff}) || fail_all)
            begin
                r.deployed  = 1'b0;
                r.tries_rec = {1'b0, max_eff} + 5'd1;
                r.finished  = 1'b1;
                r.try_count = '0;
                r.phase     = PH_IDLE;
            end
            else
            begin
                r.try_count = cur.try_count + 5'd1;
                r.phase     = PH_BURN1;
            end
        end
        return r;
    endfunction

    assign dur_burn     = TIMER_BITS'({cfg.burn_half, 1'b0});
    assign dur_rest     = TIMER_BITS'(cfg.rest);
    assign dur_recheck  = TIMER_BITS'((cfg.recheck > RECHECK_LIMIT) ? RECHECK_LIMIT
                                                                     : cfg.recheck);
    assign zero_burn    = (cfg.burn_half == '0);
    assign zero_rest    = (cfg.rest == '0);
    assign zero_recheck = (cfg.recheck == '0);
    assign eff_max      = (cfg.try_limit == '0) ? 4'd1 : cfg.try_limit;
    assign timer_dec    = (timer_reg == '0) ? timer_reg : timer_reg - TIMER_BITS'(1);

    always_comb
    begin
        w.phase     = phase_reg;
        w.try_count = try_reg;
        w.deployed  = deployed_reg;
        w.tries_rec = tries_rec_reg;
        w.finished  = finished_reg;
        w.moved     = 1'b0;
        settle_en   = 1'b0;
        zero_now    = 1'b0;

        unique case (kind)
            KIND_TICK:
            begin
                settle_en = (phase_reg != PH_IDLE);
            end
            KIND_START:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    w.try_count = 5'd1;
                    w.phase     = PH_BURN1;
                    w.moved     = 1'b1;
                    settle_en   = 1'b1;
                end
            end
            KIND_CLEAR:
            begin
                w.deployed  = 1'b0;
                w.tries_rec = '0;
                w.finished  = 1'b0;
            end
            default:
            begin
                settle_en = 1'b0;
            end
        endcase

        for (int i = 0; i < SETTLE_STEPS; i++)
        begin
            if (!w.moved)
                zero_now = (timer_dec == '0);
            else if ((w.phase == PH_BURN1) || (w.phase == PH_BURN2))
                zero_now = zero_burn;
            else if ((w.phase == PH_REST1) || (w.phase == PH_REST2))
                zero_now = zero_rest;
            else
                zero_now = zero_recheck;
            if (settle_en && (w.phase != PH_IDLE) && zero_now)
                w = end_phase(w, check_level, zero_burn && zero_rest && check_level,
                              eff_max);
        end

        if (w.moved)
        begin
            case (w.phase)
                PH_BURN1, PH_BURN2: timer_next = dur_burn;
                PH_REST1, PH_REST2: timer_next = dur_rest;
                PH_RECHECK:         timer_next = dur_recheck;
                default:            timer_next = '0;
            endcase
        end
        else if (settle_en)
        begin
            timer_next = timer_dec;
        end
        else
        begin
            timer_next = timer_reg;
        end

        phase_next     = w.phase;
        try_next       = w.try_count;
        deployed_next  = w.deployed;
        tries_rec_next = w.tries_rec;
        finished_next  = w.finished;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            try_reg       <= '0;
            deployed_reg  <= 1'b0;
            tries_rec_reg <= '0;
            finished_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            try_reg       <= try_next;
            deployed_reg  <= deployed_next;
            tries_rec_reg <= tries_rec_next;
            finished_reg  <= finished_next;
        end
    end

    assign status.ant_common_en  = (phase_reg == PH_BURN1) || (phase_reg == PH_BURN2);
    assign status.ant_one_en     = (phase_reg == PH_BURN1);
    assign status.ant_two_en     = (phase_reg == PH_BURN2);
    assign status.busy           = (phase_reg != PH_IDLE);
    assign status.finished       = finished_reg;
    assign status.deployed       = deployed_reg;
    assign status.tries_recorded = tries_rec_reg;

endmodule

[hw/rtl/antenna_burn_wire_deploy_sequencer_core.sv]
// Top level of the burn-wire antenna deployment sequencer.
// Each transfer on the input channel (a millisecond tick, a start or a clear) produces
// one result transfer carrying the burn switch drives and the deployment record as they
// stand after that item. An item is taken into the input register, and the state and
// result registers take it up once the result register is free, so its result is
// offered from those registers after the input register; the block takes one transfer
// every cycle while the result is not stalled, and the whole phase walk (zero-length
// phases fall through within the same item) is one combinational pass. A stalled
// result holds while one further item waits in the input register.
// Configuration goes through the APB port at byte offsets 0x0 burn_half_ms, 0x4 rest_ms,
// 0x8 recheck_ms and 0xC try limit; a new duration applies when its phase is next entered.
module antenna_burn_wire_deploy_sequencer_core
    import abwds_pkg::*;
#(
    parameter int TIMER_BITS = 17
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            kind,
    input  logic                  check_level,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  ant_common_en,
    output logic                  ant_one_en,
    output logic                  ant_two_en,
    output logic                  busy_res,
    output logic                  finished,
    output logic                  deployed,
    output logic [4:0]            tries_recorded,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [1:0] kind_reg;
    logic       level_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       advance;
    logic       step;
    cfg_t       cfg;
    status_t    status;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    always_comb
    begin
        in_valid_next  = in_ready ? in_valid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg  <= kind;
            level_reg <= check_level;
        end
    end

    abwds_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    abwds_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .kind        (kind_reg),
        .check_level (level_reg),
        .cfg         (cfg),
        .status      (status)
    );

    assign out_valid      = out_valid_reg;
    assign ant_common_en  = status.ant_common_en;
    assign ant_one_en     = status.ant_one_en;
    assign ant_two_en     = status.ant_two_en;
    assign busy_res       = status.busy;
    assign finished       = status.finished;
    assign deployed       = status.deployed;
    assign tries_recorded = status.tries_recorded;

endmodule

[hw/rtl/abwds_checker.sv]
// Port-level checks of the deployment sequencer, bound to the top level.
module abwds_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       ant_common_en,
    input logic       ant_one_en,
    input logic       ant_two_en,
    input logic       busy_res,
    input logic       finished,
    input logic       deployed,
    input logic [4:0] tries_recorded
);

    // burn drives: one antenna at a time, common supply with it, only while busy
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ant_common_en == (ant_one_en || ant_two_en))
                      && !(ant_one_en && ant_two_en)
                      && (!ant_common_en || busy_res))
    else $error("burn drive outputs inconsistent");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && finished) |-> (tries_recorded != 5'd0))
    else $error("finished record without a try count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !finished) |-> (!deployed && (tries_recorded == 5'd0)))
    else $error("record not clear while unfinished");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(busy_res)
                                       && $stable(finished) && $stable(tries_recorded)))
    else $error("stalled result transfer changed");

endmodule

bind antenna_burn_wire_deploy_sequencer_core abwds_checker u_checker (.*);
